// File: hdl/x86adc_pkg.sv
// shared types and codes for the x86 add-with-carry execute block
package x86adc_pkg;

  // instruction forms
  localparam logic [1:0] OP_RM_REG   = 2'd0;
  localparam logic [1:0] OP_REG_RM   = 2'd1;
  localparam logic [1:0] OP_RM_IMM   = 2'd2;
  localparam logic [1:0] OP_RM_SIMM8 = 2'd3;

  // operand sizes, the unused code is also doubleword
  localparam logic [1:0] SIZE_BYTE   = 2'd0;
  localparam logic [1:0] SIZE_WORD   = 2'd1;
  localparam logic [1:0] SIZE_DWORD  = 2'd2;
  localparam logic [1:0] SIZE_UNUSED = 2'd3;

  localparam int unsigned NUM_REGS = 8;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  operand_size;
    logic        rm_is_memory;
    logic [2:0]  rm_index;
    logic [2:0]  reg_index;
    logic [31:0] immediate;
    logic [31:0] memory_operand;
    logic [31:0] memory_address;
  } in_t;

  typedef struct packed {
    logic        write_memory;
    logic [31:0] write_address;
    logic [31:0] sum_value;
    logic        carry_out;
    logic        parity_out;
    logic        zero_out;
    logic        sign_out;
    logic        overflow_out;
  } out_t;

endpackage

// File: hdl/x86_add_with_carry_execute.sv
// x86 adc execute block: register file, carry flag, adder and result register
//
//   channel | direction | payload | accepted when
//   in      | input     | in_t    | in_valid && in_ready
//   out     | output    | out_t   | out_valid && out_ready
//
// one item per cycle sustained while out_ready stays high; an item passes the
// input stage, then the result register: register operands are read into the
// input stage at acceptance, the adder pass and the register file / carry
// update happen as it moves to the result register. a write from the item
// leaving the input stage is forwarded into the operands read in the same
// cycle. reset clears all registers and the carry. a stalled result register
// holds one item and the input stage a second one before in_ready drops.
module x86_add_with_carry_execute
  import x86adc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic [31:0] regs [NUM_REGS];
  logic        carry_flag;

  // input stage
  logic        s1_valid;
  in_t         s1;
  logic [31:0] rm_word;
  logic [31:0] reg_word;

  logic        out_free;
  logic        advance;
  logic        in_fire;

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;
  assign in_fire  = in_valid && in_ready;

  // byte indexes 4..7 address the high byte of registers 0..3
  function automatic logic [2:0] phys_index(input logic [2:0] idx, input logic [1:0] size);
    phys_index = (size == SIZE_BYTE) ? {1'b0, idx[1:0]} : idx;
  endfunction

  function automatic logic [31:0] size_mask(input logic [1:0] size);
    case (size)
      SIZE_BYTE: size_mask = 32'h0000_00ff;
      SIZE_WORD: size_mask = 32'h0000_ffff;
      default:   size_mask = 32'hffff_ffff;
    endcase
  endfunction

  function automatic logic [31:0] read_part(input logic [31:0] v, input logic hi,
                                            input logic [1:0] size);
    if (size == SIZE_BYTE && hi) begin
      read_part = {24'd0, v[15:8]};
    end else begin
      read_part = v & size_mask(size);
    end
  endfunction

  // adder pass
  logic        is_byte;
  logic        is_word;
  logic [31:0] mask;
  logic [31:0] rm_val;
  logic [31:0] reg_val;
  logic [31:0] opa;
  logic [31:0] opb;
  logic [32:0] wide;
  logic [31:0] sum;
  logic        cf;
  logic        of;
  logic        sf;
  logic [31:0] ovf_vec;
  logic        dest_reg;
  logic        to_reg_field;
  logic [2:0]  dest_raw;
  logic [2:0]  dest_phys;
  logic [31:0] dest_old;
  logic [31:0] wr_data;
  logic        wr_en;

  always_comb begin
    is_byte = (s1.operand_size == SIZE_BYTE);
    is_word = (s1.operand_size == SIZE_WORD);
    mask    = size_mask(s1.operand_size);
    rm_val  = s1.rm_is_memory ? (s1.memory_operand & mask)
                              : read_part(rm_word, s1.rm_index[2], s1.operand_size);
    reg_val = read_part(reg_word, s1.reg_index[2], s1.operand_size);

    case (s1.opcode)
      OP_RM_REG: begin
        opa = rm_val;
        opb = reg_val;
      end
      OP_REG_RM: begin
        opa = reg_val;
        opb = rm_val;
      end
      OP_RM_IMM: begin
        opa = rm_val;
        opb = s1.immediate & mask;
      end
      default: begin
        opa = rm_val;
        opb = {{24{s1.immediate[7]}}, s1.immediate[7:0]} & mask;
      end
    endcase

    wide    = {1'b0, opa} + {1'b0, opb} + {32'd0, carry_flag};
    sum     = wide[31:0] & mask;
    ovf_vec = (opa ^ sum) & (opb ^ sum);
    if (is_byte) begin
      cf = wide[8];
      of = ovf_vec[7];
      sf = sum[7];
    end else if (is_word) begin
      cf = wide[16];
      of = ovf_vec[15];
      sf = sum[15];
    end else begin
      cf = wide[32];
      of = ovf_vec[31];
      sf = sum[31];
    end

    to_reg_field = (s1.opcode == OP_REG_RM);
    dest_reg     = to_reg_field || !s1.rm_is_memory;
    dest_raw     = to_reg_field ? s1.reg_index : s1.rm_index;
    dest_phys    = phys_index(dest_raw, s1.operand_size);
    dest_old     = to_reg_field ? reg_word : rm_word;
    if (is_byte && dest_raw[2]) begin
      wr_data = {dest_old[31:16], sum[7:0], dest_old[7:0]};
    end else if (is_byte) begin
      wr_data = {dest_old[31:8], sum[7:0]};
    end else if (is_word) begin
      wr_data = {dest_old[31:16], sum[15:0]};
    end else begin
      wr_data = sum;
    end
    wr_en = advance && dest_reg;
  end

  // operand read at acceptance, forwarding the write of the leaving item
  logic [2:0] rd_rm;
  logic [2:0] rd_reg;

  assign rd_rm  = phys_index(in_data.rm_index, in_data.operand_size);
  assign rd_reg = phys_index(in_data.reg_index, in_data.operand_size);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1       <= in_data;
      rm_word  <= (wr_en && dest_phys == rd_rm) ? wr_data : regs[rd_rm];
      reg_word <= (wr_en && dest_phys == rd_reg) ? wr_data : regs[rd_reg];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= 32'd0;
      end
      carry_flag <= 1'b0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        regs[dest_phys] <= wr_data;
      end
      if (advance) begin
        carry_flag <= cf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.write_memory  <= !dest_reg;
      out_data.write_address <= dest_reg ? 32'd0 : s1.memory_address;
      out_data.sum_value     <= sum;
      out_data.carry_out     <= cf;
      out_data.parity_out    <= ~^sum[7:0];
      out_data.zero_out      <= (sum == 32'd0);
      out_data.sign_out      <= sf;
      out_data.overflow_out  <= of;
    end
  end

`ifndef ASSERT_OFF
  a_advance_loads_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("item left the input stage without reaching the result register");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input stage empty but not ready");

  a_carry_matches_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> carry_flag == out_data.carry_out)
    else $error("kept carry differs from the carry of the last result");

  a_addr_zero_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.write_memory) |-> out_data.write_address == 32'd0)
    else $error("write address set on an item without memory write");
`endif

endmodule
